/* rtl/spq_pkg.sv */
// shared types and constants for the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

    // default number of cells in the row
    localparam int CAPACITY_DEF = 16;

    // payload widths
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;

    // request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

    // operation broadcast to every cell of the row
    typedef struct packed {
        logic                      insert;
        logic                      remove;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } t_spq_op;

endpackage

/* rtl/spq_cell.sv */
// one cell of the sorted row: holds one entry and shifts with its neighbors
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  t_spq_op                   i_op,
    input  logic                      i_live,
    input  logic                      i_left_ge,
    input  logic signed [VALUE_W-1:0] i_left_value,
    input  logic signed [PRIO_W-1:0]  i_left_prio,
    input  logic signed [VALUE_W-1:0] i_right_value,
    input  logic signed [PRIO_W-1:0]  i_right_prio,
    output logic                      o_ge,
    output logic signed [VALUE_W-1:0] o_value,
    output logic signed [PRIO_W-1:0]  o_prio
);

    logic signed [VALUE_W-1:0] r_value, n_value;
    logic signed [PRIO_W-1:0]  r_prio, n_prio;

    // held entry stays ahead of the new one when its priority is not lower
    assign o_ge    = i_live && (r_prio >= i_op.prio);
    assign o_value = r_value;
    assign o_prio  = r_prio;

    // choose keep, take new entry, shift from left, or shift from right
    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_op.insert && !o_ge) begin
            if (i_left_ge) begin
                n_value = i_op.value;
                n_prio  = i_op.prio;
            end else begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end
        end else if (i_op.remove) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

endmodule

/* rtl/sorted_priority_queue.sv */
// a request's result is registered and shown in the cycle after it is accepted
// throughput: one request per cycle while results are taken; every cell of the row compares and shifts at once
// a new request is taken while the held result is taken or when no result waits
// reset (synchronous, active low) empties the queue and drops a waiting result
// cell contents are not cleared; only cells below the entry count are ever read
`timescale 1ns / 1ps

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [47:0]                s_axis_tdata,  // item_value[31:0], item_priority[47:32]
    input  logic [0:0]                 s_axis_tuser,  // kind[0]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [55:0]                m_axis_tdata,  // out_value[31:0], out_priority[47:32],
                                                      // occupancy[52:48], zero[55:53]
    output logic [2:0]                 m_axis_tuser   // status[1:0], out_valid[2]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > OCC_W) ? CW : OCC_W;

    // input request fields
    logic                      w_kind;
    logic signed [VALUE_W-1:0] w_in_value;
    logic signed [PRIO_W-1:0]  w_in_prio;
    assign w_kind     = s_axis_tuser[0];
    assign w_in_value = s_axis_tdata[VALUE_W-1:0];
    assign w_in_prio  = s_axis_tdata[VALUE_W+PRIO_W-1:VALUE_W];

    logic [CW-1:0] r_count, n_count;
    logic          r_m_valid;
    logic [STAT_W-1:0]         r_status, n_status;
    logic                      r_res_valid, n_res_valid;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic signed [PRIO_W-1:0]  r_prio, n_prio;
    logic [OCC_W-1:0]          r_occ;
    logic [EW-1:0]             w_occ_ext;

    logic    w_acc, w_full, w_empty, w_ins_ok, w_rem_ok;
    t_spq_op w_op;

    // request handshake
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_full  = (r_count >= CW'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_ins_ok = w_acc && (w_kind == KIND_INSERT) && !w_full;
    assign w_rem_ok = w_acc && (w_kind == KIND_REMOVE) && !w_empty;

    assign w_op.insert = w_ins_ok;
    assign w_op.remove = w_rem_ok;
    assign w_op.value  = w_in_value;
    assign w_op.prio   = w_in_prio;

    // row of cells
    logic signed [VALUE_W-1:0] w_cv [CAPACITY];
    logic signed [PRIO_W-1:0]  w_cp [CAPACITY];
    logic                      w_ge [CAPACITY];

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                      w_lge;
        logic signed [VALUE_W-1:0] w_lv, w_rv;
        logic signed [PRIO_W-1:0]  w_lp, w_rp;

        // head cell sees the new entry as its left neighbor
        if (gi == 0) begin : g_head
            assign w_lge = 1'b1;
            assign w_lv  = w_in_value;
            assign w_lp  = w_in_prio;
        end else begin : g_mid
            assign w_lge = w_ge[gi-1];
            assign w_lv  = w_cv[gi-1];
            assign w_lp  = w_cp[gi-1];
        end

        // tail cell keeps its own entry on a remove
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_rv = w_cv[gi];
            assign w_rp = w_cp[gi];
        end else begin : g_body
            assign w_rv = w_cv[gi+1];
            assign w_rp = w_cp[gi+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_op          (w_op),
            .i_live        (r_count > CW'(gi)),
            .i_left_ge     (w_lge),
            .i_left_value  (w_lv),
            .i_left_prio   (w_lp),
            .i_right_value (w_rv),
            .i_right_prio  (w_rp),
            .o_ge          (w_ge[gi]),
            .o_value       (w_cv[gi]),
            .o_prio        (w_cp[gi])
        );
    end

    // next count and result fields
    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_res_valid = 1'b0;
        n_value     = '0;
        n_prio      = '0;
        if (w_ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_rem_ok) begin
            n_count     = r_count - CW'(1);
            n_res_valid = 1'b1;
            n_value     = w_cv[0];
            n_prio      = w_cp[0];
        end
        if (w_kind == KIND_INSERT && w_full) begin
            n_status = ST_OVERFLOW;
        end else if (w_kind == KIND_REMOVE && w_empty) begin
            n_status = ST_UNDERFLOW;
        end
    end

    assign w_occ_ext = EW'(n_count);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status    <= n_status;
            r_res_valid <= n_res_valid;
            r_value     <= n_value;
            r_prio      <= n_prio;
            r_occ       <= w_occ_ext[OCC_W-1:0];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_occ, r_prio, r_value};
    assign m_axis_tuser  = {r_res_valid, r_status};

    // count stays within the row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // an accepted insert grows the queue by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_ok |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the queue");

    // a remove from an empty queue reports underflow and leaves the count
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_kind == KIND_REMOVE && w_empty)
        |=> (r_status == ST_UNDERFLOW) && !r_res_valid && (r_count == '0))
        else $error("underflow not reported");

    // a returned entry always carries status ok
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_res_valid) |-> (r_status == ST_OK))
        else $error("returned entry with error status");

    // head of a queue of two or more never has lower priority than the next cell
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_cp[0] >= w_cp[1]))
        else $error("queue head out of order");

endmodule

/* sim/spq_tb_pkg.sv */
// shadow queue and result checker for the sorted priority queue bench
`timescale 1ns / 1ps

package spq_tb_pkg;
    import spq_pkg::*;

    // one expected result, fields as the block reports them
    typedef struct {
        logic [STAT_W-1:0]         status;
        logic                      out_valid;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
        logic [OCC_W-1:0]          occupancy;
    } t_queue_result;

    class pq_shadow;
        // shadow copy of the sorted row, head at index 0
        logic signed [VALUE_W-1:0] held_value[CAPACITY_DEF];
        logic signed [PRIO_W-1:0]  held_prio[CAPACITY_DEF];
        int                        held_count;
        t_queue_result             awaited[$];

        int mismatches;
        int n_insert;
        int n_remove;
        int n_overflow;
        int n_underflow;
        int n_checked;
        int peak_fill;

        // work out the result of one accepted request and queue it
        function void take_request(logic kind, logic signed [VALUE_W-1:0] value,
                                   logic signed [PRIO_W-1:0] prio);
            t_queue_result r;
            int            pos;
            int            i;
            r.status    = ST_OK;
            r.out_valid = 1'b0;
            r.value     = '0;
            r.prio      = '0;
            if (kind == KIND_INSERT) begin
                n_insert++;
                if (held_count >= CAPACITY_DEF) begin
                    r.status = ST_OVERFLOW;
                    n_overflow++;
                end else begin
                    // new entry goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < held_count && held_prio[pos] >= prio) pos++;
                    for (i = held_count; i > pos; i--) begin
                        held_value[i] = held_value[i-1];
                        held_prio[i]  = held_prio[i-1];
                    end
                    held_value[pos] = value;
                    held_prio[pos]  = prio;
                    held_count++;
                end
            end else begin
                n_remove++;
                if (held_count == 0) begin
                    r.status = ST_UNDERFLOW;
                    n_underflow++;
                end else begin
                    // pop the head and close the gap
                    r.out_valid = 1'b1;
                    r.value     = held_value[0];
                    r.prio      = held_prio[0];
                    for (i = 1; i < held_count; i++) begin
                        held_value[i-1] = held_value[i];
                        held_prio[i-1]  = held_prio[i];
                    end
                    held_count--;
                end
            end
            if (held_count > peak_fill) peak_fill = held_count;
            r.occupancy = held_count[OCC_W-1:0];
            awaited.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_response(logic [55:0] data, logic [2:0] user);
            t_queue_result want;
            if (awaited.size() == 0) begin
                $display("%0t ns: result with nothing expected, expected none, got data %0h user %0h",
                         $time, data, user);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            n_checked++;
            compare_field("status", 32'(want.status), 32'(user[1:0]));
            compare_field("out_valid", 32'(want.out_valid), 32'(user[2]));
            compare_field("out_value", 32'(want.value), 32'(data[31:0]));
            compare_field("out_priority", 32'($unsigned(want.prio)), 32'(data[47:32]));
            compare_field("occupancy", 32'(want.occupancy), 32'(data[52:48]));
        endfunction
    endclass

endpackage

/* sim/tb_sorted_priority_queue.sv */
// self-checking bench for the sorted priority queue stream block
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
    import spq_pkg::*;
    import spq_tb_pkg::*;

    localparam int ITEM_TOTAL  = 1100;
    localparam int CYCLE_LIMIT = 500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // item_value[31:0], item_priority[47:32]
    logic [0:0]  s_axis_tuser = '0;   // kind[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // out_value[31:0], out_priority[47:32], occupancy[52:48]
    logic [2:0]  m_axis_tuser;        // status[1:0], out_valid[2]

    pq_shadow sb = new();
    int       n_sent = 0;
    int       burst_left = 0;
    int       cycles = 0;
    int       long_holds = 0;

    sorted_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited", cycles,
                     sb.awaited.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata, m_axis_tuser);
    end

    // sender idling: bursts of random length, random gaps between them
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // offer one request and hold it until taken
    task automatic send_request(input logic kind, input logic signed [VALUE_W-1:0] value,
                                input logic signed [PRIO_W-1:0] prio);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {prio, value};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_request(kind, value, prio);
        n_sent++;
        pace();
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick == 0) return 32'sh7FFF_FFFF;
        if (pick == 1) return 32'sh8000_0000;
        if (pick == 2) return '0;
        return $urandom;
    endfunction

    // mostly a narrow band so equal priorities are common
    function automatic logic signed [PRIO_W-1:0] rand_prio();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10) return 16'($urandom_range(0, 6)) - 16'sd3;
        if (pick == 14) return 16'sh7FFF;
        if (pick == 15) return 16'sh8000;
        if (pick == 16) return 16'sh0000;
        if (pick == 17) return 16'shFFFF;
        return 16'($urandom);
    endfunction

    // receiver stalls on a pattern of its own, with long hold-offs
    initial begin
        int mode;
        int len;
        int k;
        while (!i_rst_n) @(posedge i_clk);
        m_axis_tready <= 1'b1;
        repeat (150) @(posedge i_clk);
        forever begin
            if (long_holds == 0) mode = 3;
            else mode = $urandom_range(0, 19);
            if (mode == 3) begin
                // long hold-off so the block fills and stalls its input
                len = $urandom_range(40, 70);
                m_axis_tready <= 1'b0;
                repeat (len) @(posedge i_clk);
                long_holds++;
            end else begin
                len = $urandom_range(10, 120);
                for (k = 0; k < len; k++) begin
                    if (mode < 6) m_axis_tready <= 1'b1;
                    else if (mode < 12) m_axis_tready <= ($urandom_range(0, 1) == 1);
                    else if (mode < 17) m_axis_tready <= (k % 4 != 3);
                    else m_axis_tready <= (k % 7 < 2);
                    @(posedge i_clk);
                end
            end
        end
    end

    // stimulus and final report
    initial begin
        logic signed [VALUE_W-1:0] dir_value[16];
        logic signed [PRIO_W-1:0]  dir_prio[16];
        int                        i;
        int                        bias;
        int                        phase_len;
        logic                      kind;

        dir_value = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'shFFFF_FFFF,
                      32'sd5, 32'sd6, 32'sd7, 32'sh5555_5555,
                      32'shAAAA_AAAA, 32'sd1, 32'sd2, 32'sh1234_5678,
                      32'sd3, 32'sd8, 32'sd9, 32'sd10};
        dir_prio  = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                      16'sd5, 16'sd5, 16'sd5, 16'sh5555,
                      16'shAAAA, 16'sh7FFF, 16'sh8000, 16'sd100,
                      16'sd0, -16'sd100, 16'sd1, 16'sd200};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // remove on an empty queue, with junk in the ignored fields
        send_request(KIND_REMOVE, 32'shFFFF_FFFF, 16'shFFFF);
        // fill up with extremes and ties at top, middle and bottom
        for (i = 0; i < 16; i++) send_request(KIND_INSERT, dir_value[i], dir_prio[i]);
        // insert when full is rejected even at top priority
        send_request(KIND_INSERT, 32'sd11, 16'sh7FFF);
        for (i = 0; i < 5; i++) send_request(KIND_REMOVE, $urandom, 16'($urandom));

        // random phases: filling, draining and balanced mixes
        while (n_sent < ITEM_TOTAL) begin
            case ($urandom_range(0, 2))
                0: bias = 85;
                1: bias = 50;
                default: bias = 15;
            endcase
            phase_len = $urandom_range(20, 80);
            for (i = 0; i < phase_len && n_sent < ITEM_TOTAL; i++) begin
                kind = ($urandom_range(0, 99) < bias) ? KIND_INSERT : KIND_REMOVE;
                send_request(kind, rand_value(), rand_prio());
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d inserts (%0d rejected when full) and %0d removes (%0d on empty)",
                 sb.n_insert, sb.n_overflow, sb.n_remove, sb.n_underflow);
        $display("peak fill %0d of %0d, %0d results checked, %0d long receiver hold-offs",
                 sb.peak_fill, CAPACITY_DEF, sb.n_checked, long_holds);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
sim/spq_tb_pkg.sv
sim/tb_sorted_priority_queue.sv
